// ===== hw/rtl/sstrl_pkg.sv =====
`default_nettype none

package sstrl_pkg;

  localparam int unsigned MsWidth    = 17;
  localparam int unsigned CoordWidth = 11;

  localparam logic [MsWidth-1:0] SAT_MS        = 17'd99999;
  localparam logic [MsWidth-1:0] GREEN_LIMIT_RST = 17'd20000;
  localparam logic [7:0]         DIGIT_TOP_RST   = 8'd84;
  localparam logic [6:0]         DIGIT_WIDTH_RST = 7'd34;
  localparam logic [7:0]         DIGIT_HEIGHT_RST = 8'd72;
  localparam logic [4:0]         BAR_THICK_RST   = 5'd6;

  localparam logic [15:0] COL_BLACK = 16'h0000;
  localparam logic [15:0] COL_GREEN = 16'h07E0;
  localparam logic [15:0] COL_RED   = 16'hF800;
  localparam logic [15:0] COL_GRAY  = 16'h8410;

  localparam logic signed [CoordWidth-1:0] SCREEN_W = 11'sd280;
  localparam logic signed [CoordWidth-1:0] SCREEN_H = 11'sd240;

  localparam logic [8:0] CLEAR_LEFT   = 9'd8;
  localparam logic [7:0] CLEAR_TOP    = 8'd72;
  localparam logic [8:0] CLEAR_RIGHT  = 9'd237;
  localparam logic [7:0] CLEAR_BOTTOM = 8'd163;
  localparam logic [8:0] POINT_LEFT   = 9'd99;
  localparam logic [7:0] POINT_TOP    = 8'd146;
  localparam logic [8:0] POINT_RIGHT  = 9'd106;
  localparam logic [7:0] POINT_BOTTOM = 8'd153;

  localparam logic [2:0] LAST_DIGIT = 3'd4;
  localparam logic [2:0] LAST_SEG   = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_GREEN_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_DIGIT_TOP    = 3'd1;
  localparam logic [2:0] CFG_DIGIT_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DIGIT_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_BAR_THICK    = 3'd4;

  // bar codes, A..G
  localparam logic [2:0] SEG_A = 3'd0;
  localparam logic [2:0] SEG_B = 3'd1;
  localparam logic [2:0] SEG_C = 3'd2;
  localparam logic [2:0] SEG_D = 3'd3;
  localparam logic [2:0] SEG_E = 3'd4;
  localparam logic [2:0] SEG_F = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CLEAR,
    ST_BARS,
    ST_POINT
  } state_e;

  typedef enum logic [1:0] {
    RK_CLEAR,
    RK_BAR,
    RK_POINT
  } rect_kind_e;

  typedef logic [4:0][3:0] digits_t;

  typedef struct packed {
    logic [7:0] top;
    logic [6:0] width;
    logic [7:0] height;
    logic [4:0] thick;
  } geom_t;

  typedef struct packed {
    rect_kind_e  kind;
    logic [2:0]  digit_idx;
    logic [3:0]  digit;
    logic [2:0]  seg;
    logic [15:0] color;
  } rect_req_t;

  typedef struct packed {
    logic        keep;
    logic [8:0]  left;
    logic [7:0]  top;
    logic [8:0]  right;
    logic [7:0]  bottom;
    logic [15:0] color;
    logic        last;
  } rect_t;

  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [8:0] digit_x(input logic [2:0] idx);
    logic [8:0] x;
    unique case (idx)
      3'd0:    x = 9'd18;
      3'd1:    x = 9'd60;
      3'd2:    x = 9'd112;
      3'd3:    x = 9'd154;
      default: x = 9'd196;
    endcase
    return x;
  endfunction

  function automatic logic [MsWidth-1:0] dec_weight(input logic [1:0] idx);
    logic [MsWidth-1:0] v;
    unique case (idx)
      2'd0:    v = 17'd10000;
      2'd1:    v = 17'd1000;
      2'd2:    v = 17'd100;
      default: v = 17'd10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sstrl_digits.sv =====
`default_nettype none

// Decimal split by repeated compare-and-subtract on one shared subtractor.
module sstrl_digits (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sstrl_pkg::MsWidth-1:0] ms_i,
  output      logic                          done_o,
  output      sstrl_pkg::digits_t            digits_o
);

  logic                          busy_q, busy_d;
  logic [sstrl_pkg::MsWidth-1:0] rem_q, rem_d;
  logic [1:0]                    pow_q, pow_d;
  logic [3:0]                    cnt_q, cnt_d;
  sstrl_pkg::digits_t            digits_q, digits_d;
  logic [sstrl_pkg::MsWidth-1:0] weight;
  logic [sstrl_pkg::MsWidth-1:0] diff;
  logic                          ge;

  assign weight = sstrl_pkg::dec_weight(pow_q);
  assign ge     = rem_q >= weight;
  assign diff   = rem_q - weight;

  always_comb begin
    busy_d   = busy_q;
    rem_d    = rem_q;
    pow_d    = pow_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    done_o   = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = ms_i;
      pow_d  = 2'd0;
      cnt_d  = 4'd0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = diff;
        cnt_d = cnt_q + 4'd1;
      end else begin
        digits_d[{1'b0, pow_q}] = cnt_q;
        cnt_d = 4'd0;
        if (pow_q == 2'd3) begin
          // what is left is the units digit
          digits_d[4] = rem_q[3:0];
          busy_d      = 1'b0;
          done_o      = 1'b1;
        end else begin
          pow_d = pow_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    pow_q    <= pow_d;
    cnt_q    <= cnt_d;
    digits_q <= digits_d;
  end

  assign digits_o = digits_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sstrl_rect_gen.sv =====
`default_nettype none

// Rectangle corners for the current step, with lit and on-screen check.
module sstrl_rect_gen (
  input  wire sstrl_pkg::rect_req_t req_i,
  input  wire sstrl_pkg::geom_t     geom_i,
  output      sstrl_pkg::rect_t     rect_o
);

  typedef logic signed [sstrl_pkg::CoordWidth-1:0] coord_t;

  coord_t     x_s, y_s, w_s, h_s, t_s, half_s, th_s, tc_s;
  coord_t     l_s, tp_s, r_s, b_s;
  logic [5:0] t_inc;
  logic [6:0] pattern;
  logic       lit;
  logic       fits;

  assign x_s    = $signed({2'b00, sstrl_pkg::digit_x(req_i.digit_idx)});
  assign y_s    = $signed({3'b000, geom_i.top});
  assign w_s    = $signed({4'b0000, geom_i.width});
  assign h_s    = $signed({3'b000, geom_i.height});
  assign t_s    = $signed({6'b000000, geom_i.thick});
  assign half_s = $signed({4'b0000, geom_i.height[7:1]});
  assign th_s   = $signed({7'b0000000, geom_i.thick[4:1]});
  assign t_inc  = {1'b0, geom_i.thick} + 6'd1;
  assign tc_s   = $signed({6'b000000, t_inc[5:1]});

  always_comb begin
    unique case (req_i.seg)
      sstrl_pkg::SEG_A: begin
        l_s  = x_s + t_s;
        r_s  = x_s + w_s - t_s - 11'sd1;
        tp_s = y_s;
        b_s  = y_s + t_s - 11'sd1;
      end
      sstrl_pkg::SEG_B: begin
        l_s  = x_s + w_s - t_s;
        r_s  = x_s + w_s - 11'sd1;
        tp_s = y_s + t_s;
        b_s  = y_s + half_s - 11'sd1;
      end
      sstrl_pkg::SEG_C: begin
        l_s  = x_s + w_s - t_s;
        r_s  = x_s + w_s - 11'sd1;
        tp_s = y_s + half_s;
        b_s  = y_s + h_s - t_s - 11'sd1;
      end
      sstrl_pkg::SEG_D: begin
        l_s  = x_s + t_s;
        r_s  = x_s + w_s - t_s - 11'sd1;
        tp_s = y_s + h_s - t_s;
        b_s  = y_s + h_s - 11'sd1;
      end
      sstrl_pkg::SEG_E: begin
        l_s  = x_s;
        r_s  = x_s + t_s - 11'sd1;
        tp_s = y_s + half_s;
        b_s  = y_s + h_s - t_s - 11'sd1;
      end
      sstrl_pkg::SEG_F: begin
        l_s  = x_s;
        r_s  = x_s + t_s - 11'sd1;
        tp_s = y_s + t_s;
        b_s  = y_s + half_s - 11'sd1;
      end
      default: begin
        // middle bar, centered on half
        l_s  = x_s + t_s;
        r_s  = x_s + w_s - t_s - 11'sd1;
        tp_s = y_s + half_s - th_s;
        b_s  = y_s + half_s + tc_s - 11'sd1;
      end
    endcase
  end

  assign pattern = sstrl_pkg::seg_pattern(req_i.digit);
  assign lit     = pattern[req_i.seg];
  assign fits    = !l_s[sstrl_pkg::CoordWidth-1] && !tp_s[sstrl_pkg::CoordWidth-1] &&
                   (l_s <= r_s) && (tp_s <= b_s) &&
                   (r_s < sstrl_pkg::SCREEN_W) && (b_s < sstrl_pkg::SCREEN_H);

  always_comb begin
    rect_o.color = req_i.color;
    unique case (req_i.kind)
      sstrl_pkg::RK_CLEAR: begin
        rect_o.keep   = 1'b1;
        rect_o.left   = sstrl_pkg::CLEAR_LEFT;
        rect_o.top    = sstrl_pkg::CLEAR_TOP;
        rect_o.right  = sstrl_pkg::CLEAR_RIGHT;
        rect_o.bottom = sstrl_pkg::CLEAR_BOTTOM;
        rect_o.color  = sstrl_pkg::COL_BLACK;
        rect_o.last   = 1'b0;
      end
      sstrl_pkg::RK_POINT: begin
        rect_o.keep   = 1'b1;
        rect_o.left   = sstrl_pkg::POINT_LEFT;
        rect_o.top    = sstrl_pkg::POINT_TOP;
        rect_o.right  = sstrl_pkg::POINT_RIGHT;
        rect_o.bottom = sstrl_pkg::POINT_BOTTOM;
        rect_o.last   = 1'b1;
      end
      default: begin
        rect_o.keep   = lit && fits;
        rect_o.left   = l_s[8:0];
        rect_o.top    = tp_s[7:0];
        rect_o.right  = r_s[8:0];
        rect_o.bottom = b_s[7:0];
        rect_o.last   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_time_rect_list.sv =====
// Seven-segment time renderer: turns one elapsed time in milliseconds into a
// list of rectangle fill commands (clear, lit bars of SS.mmm, decimal point).
// Input channel: in_valid_i / in_stall_o with elapsed_ms_i. A word is taken
// when valid is high and stall is low; stall stays high from acceptance until
// the decimal point has been loaded into the output register.
// Output channel: out_valid_o / out_stall_i with the rectangle fields; one
// word per accepted rectangle, last_rect_o marks the decimal point.
// Flow: the decimal split runs on one compare/subtract unit, one step a
// cycle. Then one candidate rectangle per cycle unless the output stalls:
// 37 candidates (clear, 5 x 7 bars, point); unlit or off-screen bars take
// their step in the walk but give no word.
// A stall on the output holds the output register and freezes the bar walk.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// next edge; make them only while the block is idle.
// Reset loads the register defaults and empties the block.
`default_nettype none

module seven_segment_time_rect_list (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] elapsed_ms_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [8:0]  rect_left_o,
  output      logic [7:0]  rect_top_o,
  output      logic [8:0]  rect_right_o,
  output      logic [7:0]  rect_bottom_o,
  output      logic [15:0] rect_color_o,
  output      logic        last_rect_o
);

  sstrl_pkg::state_e    state_q, state_d;
  logic [16:0]          green_limit_q;
  sstrl_pkg::geom_t     geom_q;
  logic [2:0]           digit_q, digit_d;
  logic [2:0]           seg_q, seg_d;
  logic [15:0]          color_q, color_d;
  logic                 out_valid_q, out_valid_d;
  sstrl_pkg::rect_t     out_q;
  sstrl_pkg::rect_req_t req;
  sstrl_pkg::rect_t     rect;
  sstrl_pkg::digits_t   digits;
  logic [16:0]          ms_sat;
  logic                 accept;
  logic                 adv;
  logic                 load;
  logic                 dig_done;
  logic                 bars_end;

  assign accept   = in_valid_i && !in_stall_o;
  assign adv      = !out_valid_q || !out_stall_i;
  assign bars_end = (seg_q == sstrl_pkg::LAST_SEG) && (digit_q == sstrl_pkg::LAST_DIGIT);
  assign ms_sat   = (elapsed_ms_i > {15'd0, sstrl_pkg::SAT_MS}) ? sstrl_pkg::SAT_MS
                                                                : elapsed_ms_i[16:0];

  sstrl_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .ms_i     (ms_sat),
    .done_o   (dig_done),
    .digits_o (digits)
  );

  sstrl_rect_gen u_rect_gen (
    .req_i  (req),
    .geom_i (geom_q),
    .rect_o (rect)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sstrl_pkg::ST_IDLE:  if (accept) state_d = sstrl_pkg::ST_SPLIT;
      sstrl_pkg::ST_SPLIT: if (dig_done) state_d = sstrl_pkg::ST_CLEAR;
      sstrl_pkg::ST_CLEAR: if (adv) state_d = sstrl_pkg::ST_BARS;
      sstrl_pkg::ST_BARS:  if (adv && bars_end) state_d = sstrl_pkg::ST_POINT;
      sstrl_pkg::ST_POINT: if (adv) state_d = sstrl_pkg::ST_IDLE;
      default:             state_d = sstrl_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = 1'b1;
    req.kind      = sstrl_pkg::RK_BAR;
    req.digit_idx = digit_q;
    req.digit     = digits[digit_q];
    req.seg       = seg_q;
    req.color     = color_q;
    load          = 1'b0;
    unique case (state_q)
      sstrl_pkg::ST_IDLE: in_stall_o = 1'b0;
      sstrl_pkg::ST_CLEAR: begin
        req.kind = sstrl_pkg::RK_CLEAR;
        load     = adv;
      end
      sstrl_pkg::ST_BARS: load = adv && rect.keep;
      sstrl_pkg::ST_POINT: begin
        req.kind = sstrl_pkg::RK_POINT;
        load     = adv;
      end
      default: load = 1'b0;
    endcase
  end

  // bar walk counters and color pick
  always_comb begin
    digit_d = digit_q;
    seg_d   = seg_q;
    color_d = color_q;
    if (accept) begin
      digit_d = 3'd0;
      seg_d   = 3'd0;
      if (ms_sat == 17'd0) begin
        color_d = sstrl_pkg::COL_GRAY;
      end else if (ms_sat <= green_limit_q) begin
        color_d = sstrl_pkg::COL_GREEN;
      end else begin
        color_d = sstrl_pkg::COL_RED;
      end
    end else if (state_q == sstrl_pkg::ST_BARS && adv) begin
      if (seg_q == sstrl_pkg::LAST_SEG) begin
        seg_d   = 3'd0;
        digit_d = digit_q + 3'd1;
      end else begin
        seg_d = seg_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sstrl_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
      green_limit_q <= sstrl_pkg::GREEN_LIMIT_RST;
      geom_q.top    <= sstrl_pkg::DIGIT_TOP_RST;
      geom_q.width  <= sstrl_pkg::DIGIT_WIDTH_RST;
      geom_q.height <= sstrl_pkg::DIGIT_HEIGHT_RST;
      geom_q.thick  <= sstrl_pkg::BAR_THICK_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sstrl_pkg::CFG_GREEN_LIMIT:  green_limit_q <= cfg_data_i;
          sstrl_pkg::CFG_DIGIT_TOP:    geom_q.top    <= cfg_data_i[7:0];
          sstrl_pkg::CFG_DIGIT_WIDTH:  geom_q.width  <= cfg_data_i[6:0];
          sstrl_pkg::CFG_DIGIT_HEIGHT: geom_q.height <= cfg_data_i[7:0];
          sstrl_pkg::CFG_BAR_THICK:    geom_q.thick  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    seg_q   <= seg_d;
    color_q <= color_d;
    if (load) begin
      out_q <= rect;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_left_o   = out_q.left;
  assign rect_top_o    = out_q.top;
  assign rect_right_o  = out_q.right;
  assign rect_bottom_o = out_q.bottom;
  assign rect_color_o  = out_q.color;
  assign last_rect_o   = out_q.last;

  a_accept_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == sstrl_pkg::ST_SPLIT)
    else $error("accepted word did not start the decimal split");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  a_point_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sstrl_pkg::ST_POINT && adv) |=> (out_valid_o && last_rect_o))
    else $error("decimal point not presented as last word");

  a_done_in_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_done |-> state_q == sstrl_pkg::ST_SPLIT)
    else $error("digit split finished outside split state");

  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sstrl_pkg::ST_CLEAR && adv) |=> (out_valid_o && !last_rect_o &&
      rect_color_o == sstrl_pkg::COL_BLACK))
    else $error("clear word missing at start of list");

endmodule

`default_nettype wire
